[rtl/oid_arc_base128_encoder_macros.svh]
// assertion macros for the object identifier arc encoder
`ifndef OID_ARC_BASE128_ENCODER_MACROS_SVH
`define OID_ARC_BASE128_ENCODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define OAB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define OAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/oab_pkg.sv]
// shared types and constants for the object identifier arc encoder
package oab_pkg;

  // width of one base-128 digit and of one output byte
  localparam int DIGIT_W = 7;
  localparam int BYTE_W  = 8;

  // combined first-arc multiplier and largest single-byte value
  localparam int unsigned FIRST_MULT = 40;
  localparam logic [9:0]  BYTE_MAX   = 10'h0ff;

  // command queue depth between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // position of an arc within its identifier
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_LATER  = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  // kind of work handed to the back end
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_ARC  = 2'd2
  } cmd_kind_t;

  localparam int KIND_W = 2;

endpackage

[rtl/oab_queue.sv]
// two-entry command queue between the front and back ends
module oab_queue
  import oab_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]   mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/oab_front.sv]
// front end: tracks identifier phase and turns each arc after the first, bar dropped arcs, into a back-end command
module oab_front
  import oab_pkg::*;
#(
  parameter  int ARC_BITS = 31,
  localparam int MAXG     = (ARC_BITS + DIGIT_W - 1) / DIGIT_W,
  localparam int IW       = $clog2(MAXG),
  localparam int PW       = DIGIT_W * MAXG,
  localparam int QW       = KIND_W + IW + ARC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ARC_BITS-1:0] in_arc,
  input  logic                in_starts,
  output logic                q_push,
  input  logic                q_ready,
  output logic [QW-1:0]       q_data
);

  phase_t          phase_r, phase_nxt;
  logic [2:0]      first_r, first_nxt;
  logic            accept;
  logic [PW-1:0]   arc_pad;
  logic [9:0]      first_x40;
  logic [9:0]      combined;
  logic            over;
  logic [2:0]      first_sat;
  logic [IW-1:0]   last_idx;
  cmd_kind_t       kind;
  logic [ARC_BITS-1:0] value;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign arc_pad  = PW'(in_arc);

  // second-arc combine: 40 * first + arc, with overflow past one byte
  assign first_x40 = 10'(first_r) * 10'(FIRST_MULT);
  assign combined  = first_x40 + {2'b00, arc_pad[7:0]};
  assign over      = (|arc_pad[PW-1:BYTE_W]) || (combined > BYTE_MAX);

  // first arc saturates at seven
  assign first_sat = (|arc_pad[PW-1:3]) ? 3'd7 : arc_pad[2:0];

  // index of the most significant nonzero digit
  always_comb begin
    last_idx = '0;
    for (int i = 1; i < MAXG; i++) begin
      if ((arc_pad >> (DIGIT_W * i)) != '0) begin
        last_idx = IW'(i);
      end
    end
  end

  // phase sequencing and command issue
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    q_push    = 1'b0;
    kind      = CMD_ARC;
    value     = in_arc;
    if (accept) begin
      priority if (in_starts || phase_r == PH_FIRST) begin
        first_nxt = first_sat;
        phase_nxt = PH_SECOND;
      end else begin
        unique case (phase_r)
          PH_SECOND: begin
            q_push = 1'b1;
            if (over) begin
              kind      = CMD_ERR;
              value     = '0;
              phase_nxt = PH_DROP;
            end else begin
              kind      = CMD_BYTE;
              value     = ARC_BITS'(combined[7:0]);
              phase_nxt = PH_LATER;
            end
          end
          PH_LATER: begin
            q_push = 1'b1;
            kind   = CMD_ARC;
          end
          PH_DROP:  q_push = 1'b0;
          PH_FIRST: q_push = 1'b0;
        endcase
      end
    end
  end

  assign q_data = {kind, (kind == CMD_ARC) ? last_idx : IW'(0), value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      first_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

[rtl/oab_back.sv]
// back end: emits one content byte per cycle from the head command unless the output stalls
module oab_back
  import oab_pkg::*;
#(
  parameter  int ARC_BITS = 31,
  localparam int MAXG     = (ARC_BITS + DIGIT_W - 1) / DIGIT_W,
  localparam int IW       = $clog2(MAXG),
  localparam int PW       = DIGIT_W * MAXG,
  localparam int QW       = KIND_W + IW + ARC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [QW-1:0]     q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_err
);

  logic [ARC_BITS-1:0] value;
  logic [PW-1:0]       value_pad;
  logic [IW-1:0]       last_idx;
  cmd_kind_t           kind;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       shift_idx;
  logic [DIGIT_W-1:0]  digit;
  logic                load;
  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic                err_r, err_nxt;

  // unpack head command
  assign value     = q_data[ARC_BITS-1:0];
  assign last_idx  = q_data[ARC_BITS +: IW];
  assign kind      = cmd_kind_t'(q_data[ARC_BITS+IW +: KIND_W]);
  assign value_pad = PW'(value);

  // digit select, most significant digit first
  assign shift_idx = last_idx - idx_r;
  always_comb begin
    digit = '0;
    for (int i = 0; i < MAXG; i++) begin
      if (shift_idx == IW'(i)) begin
        digit = value_pad[DIGIT_W*i +: DIGIT_W];
      end
    end
  end

  // output register refills when empty or being drained
  assign load = q_valid && (!valid_r || out_ready);

  always_comb begin
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    valid_nxt = out_ready ? 1'b0 : valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      unique case (kind)
        CMD_BYTE: begin
          byte_nxt = value[BYTE_W-1:0];
          last_nxt = 1'b1;
          err_nxt  = 1'b0;
        end
        CMD_ERR: begin
          byte_nxt = '0;
          last_nxt = 1'b1;
          err_nxt  = 1'b1;
        end
        CMD_ARC: begin
          last_nxt = (idx_r == last_idx);
          byte_nxt = {~(idx_r == last_idx), digit};
          err_nxt  = 1'b0;
        end
        default: begin
          byte_nxt = '0;
          last_nxt = 1'b1;
          err_nxt  = 1'b0;
        end
      endcase
      if (last_nxt) begin
        q_pop   = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_err   = err_r;

endmodule

[rtl/oid_arc_base128_encoder.sv]
// top level of the object identifier arc content encoder
// Takes object identifier arcs one per transaction and emits ASN.1 content
// bytes. The front end takes one arc per cycle while the command queue has
// room: a first arc (in_tuser high, or the first arc after reset) is stored
// and yields nothing, the second arc yields one byte 40*first+second or one
// error byte (out_tuser high, data 0) after which arcs are dropped until the
// next first arc, and each later arc yields its minimal big-endian base-128
// form with bit 7 set on all bytes but the last (out_tlast). The back end
// emits one byte per cycle while out_tready is high, and an arc takes 1 to
// (ARC_BITS+6)/7 bytes, five at the default width. A two-entry command queue
// sits between the ends; the output register accepts a new byte in the cycle
// its current one is taken. A command is queued, then its bytes registered.
module oid_arc_base128_encoder
  import oab_pkg::*;
#(
  parameter  int ARC_BITS = 31,
  localparam int IN_W     = ((ARC_BITS + 7) / 8) * 8,
  localparam int MAXG     = (ARC_BITS + DIGIT_W - 1) / DIGIT_W,
  localparam int IW       = $clog2(MAXG),
  localparam int QW       = KIND_W + IW + ARC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // arc, zero padded above
  input  logic              in_tuser,   // starts_oid
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // out_byte
  output logic              out_tlast,  // last_of_arc
  output logic              out_tuser   // error
);

`include "oid_arc_base128_encoder_macros.svh"

  logic          q_push;
  logic          q_ready;
  logic [QW-1:0] q_wdata;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_rdata;

  // arc classification
  oab_front #(
    .ARC_BITS (ARC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_arc    (in_tdata[ARC_BITS-1:0]),
    .in_starts (in_tuser),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_data    (q_wdata)
  );

  // command queue
  oab_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  // byte emission
  oab_back #(
    .ARC_BITS (ARC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_err   (out_tuser)
  );

  // error byte is a lone zero byte closing its arc
  `OAB_ASSERT_SAME(a_err_shape, out_tvalid && out_tuser, (out_tdata == '0) && out_tlast, "error byte malformed")

  // continuation bit on every byte that is not the last of its arc
  `OAB_ASSERT_SAME(a_cont_bit, out_tvalid && !out_tlast, out_tdata[BYTE_W-1] && !out_tuser, "missing continuation bit")

  // a first arc never issues work to the back end
  `OAB_ASSERT_SAME(a_first_silent, in_tvalid && in_tready && in_tuser, !q_push, "first arc issued a command")

  // a byte leaving the back end on a pop is shown next cycle
  `OAB_ASSERT_NEXT(a_pop_shows, q_pop, out_tvalid && out_tlast, "popped command not presented")

endmodule
